// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the integer ALU.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/mia_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer ALU package
// Widths, operation codes, control codes and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package mia_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int HALF_WIDTH  = DATA_WIDTH / 2;
	localparam int OP_WIDTH    = 4;
	localparam int SHAMT_WIDTH = 5;

	localparam logic [OP_WIDTH-1:0] OP_ADD  = 4'd0;
	localparam logic [OP_WIDTH-1:0] OP_ADDU = 4'd1;
	localparam logic [OP_WIDTH-1:0] OP_SUB  = 4'd2;
	localparam logic [OP_WIDTH-1:0] OP_AND  = 4'd3;
	localparam logic [OP_WIDTH-1:0] OP_OR   = 4'd4;
	localparam logic [OP_WIDTH-1:0] OP_XOR  = 4'd5;
	localparam logic [OP_WIDTH-1:0] OP_NOR  = 4'd6;
	localparam logic [OP_WIDTH-1:0] OP_NAND = 4'd7;
	localparam logic [OP_WIDTH-1:0] OP_SLT  = 4'd8;
	localparam logic [OP_WIDTH-1:0] OP_SLL  = 4'd9;
	localparam logic [OP_WIDTH-1:0] OP_SRL  = 4'd10;
	localparam logic [OP_WIDTH-1:0] OP_SRA  = 4'd11;
	localparam logic [OP_WIDTH-1:0] OP_LUI  = 4'd12;

	localparam logic [2:0] UNIT_ZERO  = 3'd0;
	localparam logic [2:0] UNIT_ADD   = 3'd1;
	localparam logic [2:0] UNIT_SLT   = 3'd2;
	localparam logic [2:0] UNIT_LOGIC = 3'd3;
	localparam logic [2:0] UNIT_SHIFT = 3'd4;
	localparam logic [2:0] UNIT_LUI   = 3'd5;

	localparam logic [2:0] LF_AND  = 3'd0;
	localparam logic [2:0] LF_OR   = 3'd1;
	localparam logic [2:0] LF_XOR  = 3'd2;
	localparam logic [2:0] LF_NOR  = 3'd3;
	localparam logic [2:0] LF_NAND = 3'd4;

	localparam logic [1:0] SH_SLL = 2'd0;
	localparam logic [1:0] SH_SRL = 2'd1;
	localparam logic [1:0] SH_SRA = 2'd2;

	typedef struct packed {
		logic [OP_WIDTH-1:0]    op;
		logic [DATA_WIDTH-1:0]  operand_a;
		logic [DATA_WIDTH-1:0]  operand_b;
		logic [SHAMT_WIDTH-1:0] shift_amount;
	} alu_req_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] alu_result;
		logic                  overflow;
	} alu_rsp_t;

	typedef struct packed {
		logic [2:0] unit;
		logic       sub;
		logic       ovf_en;
		logic [2:0] logic_fn;
		logic [1:0] shift_fn;
	} alu_ctrl_t;

	typedef struct packed {
		alu_ctrl_t              ctrl;
		logic [DATA_WIDTH-1:0]  operand_a;
		logic [DATA_WIDTH-1:0]  operand_b;
		logic [SHAMT_WIDTH-1:0] shift_amount;
	} alu_dec_t;

	typedef struct packed {
		alu_ctrl_t             ctrl;
		logic                  sign_a;
		logic                  sign_b;
		logic [DATA_WIDTH-1:0] sum;
		logic [DATA_WIDTH-1:0] logic_r;
		logic [DATA_WIDTH-1:0] shift_r;
		logic [DATA_WIDTH-1:0] lui_r;
	} alu_exec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mips_integer_alu.sv =====
// ----------------------------------------------------------------------------
// MIPS32 integer ALU
// Three-stage pipelined ALU: decode, execute, result select.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | alu_req_t
//   rsp     | out       | rsp_valid, rsp_stall | alu_rsp_t
//
// One transaction per cycle while rsp_stall is low; an accepted request is
// registered in the decode, execute and select stages in turn before rsp_valid
// rises and the response can be accepted.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall holds only the stages that carry a transaction; empty stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_integer_alu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  mia_pkg::alu_req_t     req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output mia_pkg::alu_rsp_t     rsp
);
	import mia_pkg::*;

	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      adv1;
	logic      adv2;
	logic      adv3;
	alu_dec_t  dec_s1;
	alu_exec_t exec_s2;

	assign adv3 = !valid_s3 || !rsp_stall;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign req_stall = !adv1;
	assign rsp_valid = valid_s3;

	mia_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv1),
		.in_valid (req_valid),
		.req      (req),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	mia_execute u_execute (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv2),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s2 (valid_s2),
		.exec_s2  (exec_s2)
	);

	mia_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv3),
		.valid_s2 (valid_s2),
		.exec_s2  (exec_s2),
		.valid_s3 (valid_s3),
		.rsp_s3   (rsp)
	);

`include "assert_macros.svh"

	`ASSERT_IMPLY(a_free_flow, clk, arst_n, !rsp_stall, !req_stall)
	`ASSERT_IMPLY(a_full_stall, clk, arst_n,
		valid_s1 && valid_s2 && valid_s3 && rsp_stall, req_stall)
	`ASSERT_NEXT(a_accept_loads, clk, arst_n, req_valid && !req_stall, valid_s1)

endmodule

`default_nettype wire

// ===== hw/rtl/mia_decode.sv =====
// ----------------------------------------------------------------------------
// Integer ALU decode stage
// Decodes the operation code into unit controls and registers the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module mia_decode (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             in_valid,
	input  mia_pkg::alu_req_t     req,
	output logic                  valid_s1,
	output mia_pkg::alu_dec_t     dec_s1
);
	import mia_pkg::*;

	alu_ctrl_t ctrl;

	always_comb begin
		ctrl = '0;
		ctrl.unit = UNIT_ZERO;
		ctrl.logic_fn = LF_AND;
		ctrl.shift_fn = SH_SLL;
		case (req.op)
			OP_ADD: begin
				ctrl.unit = UNIT_ADD;
				ctrl.ovf_en = 1'b1;
			end
			OP_ADDU: ctrl.unit = UNIT_ADD;
			OP_SUB: begin
				ctrl.unit = UNIT_ADD;
				ctrl.sub = 1'b1;
				ctrl.ovf_en = 1'b1;
			end
			OP_AND: ctrl.unit = UNIT_LOGIC;
			OP_OR: begin
				ctrl.unit = UNIT_LOGIC;
				ctrl.logic_fn = LF_OR;
			end
			OP_XOR: begin
				ctrl.unit = UNIT_LOGIC;
				ctrl.logic_fn = LF_XOR;
			end
			OP_NOR: begin
				ctrl.unit = UNIT_LOGIC;
				ctrl.logic_fn = LF_NOR;
			end
			OP_NAND: begin
				ctrl.unit = UNIT_LOGIC;
				ctrl.logic_fn = LF_NAND;
			end
			OP_SLT: begin
				ctrl.unit = UNIT_SLT;
				ctrl.sub = 1'b1;
			end
			OP_SLL: ctrl.unit = UNIT_SHIFT;
			OP_SRL: begin
				ctrl.unit = UNIT_SHIFT;
				ctrl.shift_fn = SH_SRL;
			end
			OP_SRA: begin
				ctrl.unit = UNIT_SHIFT;
				ctrl.shift_fn = SH_SRA;
			end
			OP_LUI: ctrl.unit = UNIT_LUI;
			default: ctrl.unit = UNIT_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dec_s1.ctrl <= ctrl;
			dec_s1.operand_a <= req.operand_a;
			dec_s1.operand_b <= req.operand_b;
			dec_s1.shift_amount <= req.shift_amount;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mia_execute.sv =====
// ----------------------------------------------------------------------------
// Integer ALU execute stage
// Runs the adder, the logic unit, the shifter and the upper load in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module mia_execute (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             valid_s1,
	input  mia_pkg::alu_dec_t     dec_s1,
	output logic                  valid_s2,
	output mia_pkg::alu_exec_t    exec_s2
);
	import mia_pkg::*;

	logic [DATA_WIDTH-1:0] b_eff;
	logic [DATA_WIDTH-1:0] sum;
	logic [DATA_WIDTH-1:0] logic_r;
	logic [DATA_WIDTH-1:0] shift_r;
	logic [DATA_WIDTH-1:0] lui_r;

	assign b_eff = dec_s1.operand_b ^ {DATA_WIDTH{dec_s1.ctrl.sub}};
	assign sum = dec_s1.operand_a + b_eff + DATA_WIDTH'(dec_s1.ctrl.sub);
	assign lui_r = {dec_s1.operand_b[HALF_WIDTH-1:0], {HALF_WIDTH{1'b0}}};

	always_comb begin
		case (dec_s1.ctrl.logic_fn)
			LF_AND:  logic_r = dec_s1.operand_a & dec_s1.operand_b;
			LF_OR:   logic_r = dec_s1.operand_a | dec_s1.operand_b;
			LF_XOR:  logic_r = dec_s1.operand_a ^ dec_s1.operand_b;
			LF_NOR:  logic_r = ~(dec_s1.operand_a | dec_s1.operand_b);
			LF_NAND: logic_r = ~(dec_s1.operand_a & dec_s1.operand_b);
			default: logic_r = '0;
		endcase
	end

	always_comb begin
		case (dec_s1.ctrl.shift_fn)
			SH_SLL:  shift_r = dec_s1.operand_b << dec_s1.shift_amount;
			SH_SRL:  shift_r = dec_s1.operand_b >> dec_s1.shift_amount;
			SH_SRA:  shift_r = $unsigned($signed(dec_s1.operand_b) >>> dec_s1.shift_amount);
			default: shift_r = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			exec_s2.ctrl <= dec_s1.ctrl;
			exec_s2.sign_a <= dec_s1.operand_a[DATA_WIDTH-1];
			exec_s2.sign_b <= dec_s1.operand_b[DATA_WIDTH-1];
			exec_s2.sum <= sum;
			exec_s2.logic_r <= logic_r;
			exec_s2.shift_r <= shift_r;
			exec_s2.lui_r <= lui_r;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mia_select.sv =====
// ----------------------------------------------------------------------------
// Integer ALU select stage
// Picks the unit result, forms overflow and set-less-than, holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mia_select (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             valid_s2,
	input  mia_pkg::alu_exec_t    exec_s2,
	output logic                  valid_s3,
	output mia_pkg::alu_rsp_t     rsp_s3
);
	import mia_pkg::*;

	logic     sign_r;
	logic     less;
	logic     ovf;
	alu_rsp_t rsp;

	assign sign_r = exec_s2.sum[DATA_WIDTH-1];
	assign less = (exec_s2.sign_a != exec_s2.sign_b) ? exec_s2.sign_a : sign_r;
	assign ovf = exec_s2.ctrl.ovf_en
		&& (exec_s2.sign_a == (exec_s2.sign_b ^ exec_s2.ctrl.sub))
		&& (sign_r != exec_s2.sign_a);

	always_comb begin
		rsp.overflow = ovf;
		case (exec_s2.ctrl.unit)
			UNIT_ADD:   rsp.alu_result = exec_s2.sum;
			UNIT_SLT:   rsp.alu_result = DATA_WIDTH'(less);
			UNIT_LOGIC: rsp.alu_result = exec_s2.logic_r;
			UNIT_SHIFT: rsp.alu_result = exec_s2.shift_r;
			UNIT_LUI:   rsp.alu_result = exec_s2.lui_r;
			default:    rsp.alu_result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s3 <= rsp;
		end
	end

endmodule

`default_nettype wire
